FILE: design/wsia_pkg.sv
`default_nettype none

package wsia_pkg;

   // Operation codes carried on req_op. The fourth code is unused and yields zero.
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;

   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2,
      WIDTH_64 = 2'd3
   } width_type;

   // Load enables for the three multiplier stages.
   typedef struct packed {
      logic prod;
      logic mid;
      logic sum;
   } mul_adv_type;

endpackage

`default_nettype wire

FILE: design/wsia_mul.sv
`default_nettype none

module wsia_mul
   import wsia_pkg::*;
(
   input  wire                 clock,
   input  wire mul_adv_type    adv,
   input  wire signed [63:0]   operand_a,
   input  wire signed [63:0]   operand_b,
   output logic       [127:0]  product
);

   // Each operand splits into a signed upper half and an unsigned lower half.
   // All four partial products are 33 x 33 signed multiplies.
   logic signed [32:0] a_lo;
   logic signed [32:0] a_hi;
   logic signed [32:0] b_lo;
   logic signed [32:0] b_hi;

   logic signed [65:0] pll_ff, plh_ff, phl_ff, phh_ff;
   logic signed [65:0] pll_in, plh_in, phl_in, phh_in;
   logic signed [66:0] mid_ff, mid_in;
   logic signed [65:0] pll2_ff, phh2_ff;
   logic       [127:0] product_ff, product_in;

   always_comb begin
      a_lo   = $signed({1'b0, operand_a[31:0]});
      a_hi   = $signed({operand_a[63], operand_a[63:32]});
      b_lo   = $signed({1'b0, operand_b[31:0]});
      b_hi   = $signed({operand_b[63], operand_b[63:32]});
      pll_in = a_lo * b_lo;
      plh_in = a_lo * b_hi;
      phl_in = a_hi * b_lo;
      phh_in = a_hi * b_hi;
      mid_in = {plh_ff[65], plh_ff} + {phl_ff[65], phl_ff};
      product_in = {{62{pll2_ff[65]}}, pll2_ff}
                 + {{29{mid_ff[66]}}, mid_ff, 32'd0}
                 + {phh2_ff[63:0], 64'd0};
   end

   always_ff @(posedge clock) begin
      if (adv.prod) begin
         pll_ff <= pll_in;
         plh_ff <= plh_in;
         phl_ff <= phl_in;
         phh_ff <= phh_in;
      end
      if (adv.mid) begin
         mid_ff  <= mid_in;
         pll2_ff <= pll_ff;
         phh2_ff <= phh_ff;
      end
      if (adv.sum) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

`default_nettype wire

FILE: design/wrap_saturate_int_alu_core.sv
// Signed add, subtract and multiply at 8, 16, 32 or 64 bits, wrapping or saturating.
// Throughput: one transfer per cycle while rsp_ready does not stall the pipeline; five register
// stages, the 64 x 64 multiply is split into four 33 x 33 partial products summed over
// two further stages.
// Reset is synchronous and active high; it clears only the stage valid bits.
`default_nettype none

module wrap_saturate_int_alu_core
   import wsia_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire         [1:0]  req_op,
   input  wire                req_saturate,
   input  wire         [1:0]  req_width_sel,
   input  wire signed  [63:0] req_operand_a,
   input  wire signed  [63:0] req_operand_b,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic signed [63:0] rsp_result
);

   // Saturation limits, already sign-extended to 64 bits.
   localparam logic [63:0] MIN_8  = 64'hFFFF_FFFF_FFFF_FF80;
   localparam logic [63:0] MAX_8  = 64'h0000_0000_0000_007F;
   localparam logic [63:0] MIN_16 = 64'hFFFF_FFFF_FFFF_8000;
   localparam logic [63:0] MAX_16 = 64'h0000_0000_0000_7FFF;
   localparam logic [63:0] MIN_32 = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] MAX_32 = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] MIN_64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_64 = 64'h7FFF_FFFF_FFFF_FFFF;

   // Stage valid bits: index 0 is the input register, index 4 the output register.
   // A stage loads whenever it is empty or the stage after it loads this cycle,
   // so bubbles collapse and a full pipeline stalls as one.
   logic [4:0] valid_ff, valid_in;
   logic [4:0] load;

   // Stage 1: operands sign-extended from the selected width.
   logic        [1:0]  op1_ff;
   logic               sat1_ff;
   width_type          width1_ff;
   logic signed [63:0] a1_ff, a1_in;
   logic signed [63:0] b1_ff, b1_in;

   // Stage 2: exact sum or difference; partial products live in the multiplier.
   logic        [1:0]  op2_ff, op3_ff, op4_ff;
   logic               sat2_ff, sat3_ff, sat4_ff;
   width_type          width2_ff, width3_ff, width4_ff, width5_ff;
   logic        [64:0] sum2_ff, sum2_in, sum3_ff, sum4_ff;

   mul_adv_type        mul_adv;
   logic       [127:0] product;

   // Stage 5: final result.
   logic       [127:0] exact;
   logic               fits;
   logic       [63:0]  wrapped;
   logic       [63:0]  limit;
   logic       [63:0]  result_ff, result_in;

   always_comb begin
      load[4] = !valid_ff[4] || rsp_ready;
      load[3] = !valid_ff[3] || load[4];
      load[2] = !valid_ff[2] || load[3];
      load[1] = !valid_ff[1] || load[2];
      load[0] = !valid_ff[0] || load[1];
      valid_in[0] = load[0] ? req_valid   : valid_ff[0];
      valid_in[1] = load[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = load[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = load[3] ? valid_ff[2] : valid_ff[3];
      valid_in[4] = load[4] ? valid_ff[3] : valid_ff[4];
   end

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[4];
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Bits above the selected width are ignored: the operand is sign-extended
   // from the top bit of that width.
   always_comb begin
      unique case (width_type'(req_width_sel))
         WIDTH_8: begin
            a1_in = {{56{req_operand_a[7]}}, req_operand_a[7:0]};
            b1_in = {{56{req_operand_b[7]}}, req_operand_b[7:0]};
         end
         WIDTH_16: begin
            a1_in = {{48{req_operand_a[15]}}, req_operand_a[15:0]};
            b1_in = {{48{req_operand_b[15]}}, req_operand_b[15:0]};
         end
         WIDTH_32: begin
            a1_in = {{32{req_operand_a[31]}}, req_operand_a[31:0]};
            b1_in = {{32{req_operand_b[31]}}, req_operand_b[31:0]};
         end
         default: begin
            a1_in = req_operand_a;
            b1_in = req_operand_b;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         op1_ff    <= req_op;
         sat1_ff   <= req_saturate;
         width1_ff <= width_type'(req_width_sel);
         a1_ff     <= a1_in;
         b1_ff     <= b1_in;
      end
   end

   // The 65-bit sum never overflows, so it is the exact result of add or subtract.
   always_comb begin
      if (op1_ff == OP_SUB) begin
         sum2_in = {a1_ff[63], a1_ff} - {b1_ff[63], b1_ff};
      end else begin
         sum2_in = {a1_ff[63], a1_ff} + {b1_ff[63], b1_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         op2_ff    <= op1_ff;
         sat2_ff   <= sat1_ff;
         width2_ff <= width1_ff;
         sum2_ff   <= sum2_in;
      end
      if (load[2]) begin
         op3_ff    <= op2_ff;
         sat3_ff   <= sat2_ff;
         width3_ff <= width2_ff;
         sum3_ff   <= sum2_ff;
      end
      if (load[3]) begin
         op4_ff    <= op3_ff;
         sat4_ff   <= sat3_ff;
         width4_ff <= width3_ff;
         sum4_ff   <= sum3_ff;
      end
   end

   // The multiplier's three stages move with stages 2, 3 and 4.
   assign mul_adv.prod = load[1];
   assign mul_adv.mid  = load[2];
   assign mul_adv.sum  = load[3];

   wsia_mul u_mul (
      .clock     (clock),
      .adv       (mul_adv),
      .operand_a (a1_ff),
      .operand_b (b1_ff),
      .product   (product)
   );

   // The exact result is held as a 128-bit signed value. It fits the selected
   // width when every bit from the top of that width upward equals the sign.
   // The unused operation code gives zero, which always fits.
   always_comb begin
      unique case (op4_ff)
         OP_ADD, OP_SUB: exact = {{63{sum4_ff[64]}}, sum4_ff};
         OP_MUL:         exact = product;
         default:        exact = '0;
      endcase
      unique case (width4_ff)
         WIDTH_8: begin
            fits    = (exact[127:7] == '0) || (exact[127:7] == '1);
            wrapped = {{56{exact[7]}}, exact[7:0]};
            limit   = exact[127] ? MIN_8 : MAX_8;
         end
         WIDTH_16: begin
            fits    = (exact[127:15] == '0) || (exact[127:15] == '1);
            wrapped = {{48{exact[15]}}, exact[15:0]};
            limit   = exact[127] ? MIN_16 : MAX_16;
         end
         WIDTH_32: begin
            fits    = (exact[127:31] == '0) || (exact[127:31] == '1);
            wrapped = {{32{exact[31]}}, exact[31:0]};
            limit   = exact[127] ? MIN_32 : MAX_32;
         end
         default: begin
            fits    = (exact[127:63] == '0) || (exact[127:63] == '1);
            wrapped = exact[63:0];
            limit   = exact[127] ? MIN_64 : MAX_64;
         end
      endcase
      result_in = (!sat4_ff || fits) ? wrapped : limit;
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         result_ff <= result_in;
         width5_ff <= width4_ff;
      end
   end

`ifndef SYNTHESIS
   // A request transfer always lands in the input stage.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted request did not enter stage 1");

   // The pipeline only pushes back when every stage holds an item.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (valid_ff == 5'b11111))
      else $error("request stalled while a stage was empty");

   // A stalled middle stage keeps its item.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && !load[2] |=> valid_ff[2])
      else $error("stalled stage 3 dropped its item");

   // An 8-bit result is always sign-extended from bit 7.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (width5_ff == WIDTH_8) |->
         (rsp_result[63:7] == '0) || (rsp_result[63:7] == '1))
      else $error("8-bit result not sign-extended");
`endif

endmodule

`default_nettype wire

FILE: test/alu_result_check.sv
`default_nettype none

module alu_result_check
   import wsia_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_ready,
   input  wire        [1:0]  req_op,
   input  wire               req_saturate,
   input  wire        [1:0]  req_width_sel,
   input  wire signed [63:0] req_operand_a,
   input  wire signed [63:0] req_operand_b,
   input  wire               rsp_valid,
   input  wire               rsp_ready,
   input  wire signed [63:0] rsp_result,
   output int                mismatches,
   output int                pending
);

   timeunit 1ns;
   timeprecision 1ps;

   logic signed [63:0] expected_results[$];
   logic signed [63:0] want;

   // Keeps the low bits of x and sign-extends them to 64 bits.
   function automatic logic signed [63:0] narrow_to_width(logic [63:0] x, int unsigned bits);
      logic signed [63:0] t;
      t = x << (64 - bits);
      return t >>> (64 - bits);
   endfunction

   // The exact result is formed at 130 bits, where even a 64 x 64 product fits,
   // and is then either clamped to the width's range or cut back to the width.
   function automatic logic signed [63:0] alu_result(logic [1:0] op, logic sat,
                                                     width_type ws,
                                                     logic [63:0] a, logic [63:0] b);
      int unsigned bits;
      logic signed [129:0] xa, xb, exact, top, bottom;
      case (ws)
         WIDTH_8:  bits = 8;
         WIDTH_16: bits = 16;
         WIDTH_32: bits = 32;
         default:  bits = 64;
      endcase
      if (op != OP_ADD && op != OP_SUB && op != OP_MUL) return '0;
      xa = narrow_to_width(a, bits);
      xb = narrow_to_width(b, bits);
      case (op)
         OP_ADD:  exact = xa + xb;
         OP_SUB:  exact = xa - xb;
         default: exact = xa * xb;
      endcase
      top    = (130'sd1 <<< (bits - 1)) - 130'sd1;
      bottom = -(130'sd1 <<< (bits - 1));
      if (sat && exact > top) return top[63:0];
      if (sat && exact < bottom) return bottom[63:0];
      return narrow_to_width(exact[63:0], bits);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result %h arrived with nothing outstanding", $realtime,
                           rsp_result);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: result mismatch, expected %h, got %h", $realtime,
                              want, rsp_result);
               end
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(alu_result(req_op, req_saturate,
                                                  width_type'(req_width_sel),
                                                  req_operand_a, req_operand_b));
      end
      pending = expected_results.size();
   end

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

// Testbench for the saturating and wrapping integer ALU. The top only makes
// stimulus and gives the verdict; alu_result_check watches both channels,
// predicts every result and counts mismatches.
module tb
   import wsia_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic        [1:0]  req_op = OP_ADD;
   logic               req_saturate = 1'b0;
   logic        [1:0]  req_width_sel = WIDTH_8;
   logic signed [63:0] req_operand_a = '0;
   logic signed [63:0] req_operand_b = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [63:0] rsp_result;

   int mismatches;
   int pending;

   // The stimulus process bumps this to ask the response side for one long
   // hold-off; the response side keeps its own count of those it has served.
   int hold_off_asks = 0;
   int hold_offs_served = 0;

   // Number of upcoming transfers to send back to back, with no gaps.
   int burst_left = 0;

   // The fourth operation code has no name in the package; it must yield zero.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

   wrap_saturate_int_alu_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_saturate  (req_saturate),
      .req_width_sel (req_width_sel),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result    (rsp_result)
   );

   alu_result_check check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_saturate  (req_saturate),
      .req_width_sel (req_width_sel),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result    (rsp_result),
      .mismatches    (mismatches),
      .pending       (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offers one request and returns at the edge where its transfer happens.
   // Valid is only raised here, so back-to-back requests never see it dropped.
   task automatic send_request(logic [1:0] op, logic sat, width_type ws,
                               logic [63:0] a, logic [63:0] b);
      req_valid     <= 1'b1;
      req_op        <= op;
      req_saturate  <= sat;
      req_width_sel <= ws;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Idle time on the request side after a transfer: mostly none or a few
   // cycles, now and then a long pause. During a burst there is no idling.
   task automatic request_gap();
      int roll;
      int cycles;
      roll = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         cycles = 0;
      end else if (roll < 55) cycles = 0;
      else if (roll < 90) cycles = $urandom_range(1, 3);
      else cycles = $urandom_range(5, 30);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Operands lean toward the edges of the selected width, where wrapping and
   // clamping happen, and toward magnitudes of about half the width, whose
   // products straddle the overflow point. Bits above the width are random.
   function automatic logic [63:0] pick_operand(width_type ws);
      int unsigned bits;
      logic [63:0] noise, field, keep;
      bits  = 8 << int'(ws);
      noise = {$urandom, $urandom};
      keep  = (bits == 64) ? '1 : (64'd1 << bits) - 64'd1;
      case ($urandom_range(0, 10))
         0, 1, 2: field = {$urandom, $urandom};
         3:       field = keep >> 1;
         4:       field = ~(keep >> 1);
         5:       field = 64'($urandom_range(0, 15));
         6:       field = -64'($urandom_range(1, 16));
         7:       field = (keep >> 1) - 64'($urandom_range(0, 3));
         8:       field = ~(keep >> 1) + 64'($urandom_range(0, 3));
         default: begin
            field = {$urandom, $urandom} >> (63 - bits / 2);
            if ($urandom_range(0, 1) == 1) field = -field;
         end
      endcase
      return (noise & ~keep) | (field & keep);
   endfunction

   // Response side: random runs of ready and stalls, some of them long, plus
   // stretches with no stalls at all. When asked, it holds off long enough for
   // the pipeline to fill and push back on the request side.
   initial begin
      int roll;
      int cycles;
      forever begin
         if (hold_off_asks != hold_offs_served) begin
            hold_offs_served++;
            rsp_ready <= 1'b0;
            repeat (150) @(posedge clock);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               rsp_ready <= 1'b1;
               cycles = $urandom_range(40, 150);
            end else if (roll < 60) begin
               rsp_ready <= 1'b1;
               cycles = $urandom_range(1, 8);
            end else if (roll < 92) begin
               rsp_ready <= 1'b0;
               cycles = $urandom_range(1, 3);
            end else begin
               rsp_ready <= 1'b0;
               cycles = $urandom_range(10, 40);
            end
            repeat (cycles) @(posedge clock);
         end
      end
   end

   initial begin
      logic [1:0] op;
      width_type  ws;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: wrap and clamp at each width and for each operation, the
      // unused operation code, ignored upper operand bits and zero products.
      send_request(OP_ADD, 1'b0, WIDTH_8, 64'd127, 64'd1);                  request_gap();
      send_request(OP_ADD, 1'b1, WIDTH_8, 64'd127, 64'd1);                  request_gap();
      send_request(OP_ADD, 1'b1, WIDTH_8, 64'hff80, '1);                     request_gap();
      send_request(OP_SUB, 1'b1, WIDTH_16, 64'h8000, 64'd1);                request_gap();
      send_request(OP_SUB, 1'b0, WIDTH_16, 64'hdead_beef_0000_8000, 64'd1); request_gap();
      send_request(OP_MUL, 1'b1, WIDTH_32, 64'h8000_0000, '1);               request_gap();
      send_request(OP_MUL, 1'b0, WIDTH_32, 64'h8000_0000, '1);               request_gap();
      send_request(OP_MUL, 1'b1, WIDTH_16, 64'hff80, 64'hff00);             request_gap();
      send_request(OP_MUL, 1'b1, WIDTH_64, MIN64, '1);                       request_gap();
      send_request(OP_MUL, 1'b1, WIDTH_64, MIN64, 64'd1);                   request_gap();
      send_request(OP_MUL, 1'b1, WIDTH_64, MAX64, MAX64);                   request_gap();
      send_request(OP_MUL, 1'b1, WIDTH_64, MAX64, MIN64);                   request_gap();
      send_request(OP_MUL, 1'b0, WIDTH_64, MIN64, MIN64);                   request_gap();
      send_request(OP_ADD, 1'b1, WIDTH_64, MAX64, MAX64);                   request_gap();
      send_request(OP_ADD, 1'b0, WIDTH_64, '1, '1);                         request_gap();
      send_request(OP_SUB, 1'b1, WIDTH_64, MIN64, MAX64);                   request_gap();
      send_request(OP_SUB, 1'b0, WIDTH_64, MIN64, 64'd1);                   request_gap();
      send_request(OP_MUL, 1'b1, WIDTH_8, 64'hffff_ff00, 64'h80);           request_gap();
      send_request(OP_MUL, 1'b1, WIDTH_64, 64'd0, MAX64);                   request_gap();
      send_request(OP_UNUSED, 1'b1, WIDTH_64, '1, '1);                      request_gap();
      send_request(OP_UNUSED, 1'b0, WIDTH_8, MAX64, MIN64);                 request_gap();

      // Random part. Twice a burst of back-to-back requests starts together
      // with a long response hold-off, so the block fills up and stalls.
      for (int n = 0; n < 1950; n++) begin
         if (n == 300 || n == 1300) begin
            burst_left = 200;
            hold_off_asks++;
         end
         op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
         ws = width_type'($urandom_range(0, 3));
         send_request(op, 1'($urandom_range(0, 1)), ws, pick_operand(ws), pick_operand(ws));
         request_gap();
      end
      req_valid <= 1'b0;

      // Drain every outstanding result, then allow a few more cycles for
      // anything stray to surface.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
design/wsia_pkg.sv
design/wsia_mul.sv
design/wrap_saturate_int_alu_core.sv
test/alu_result_check.sv
test/tb.sv
